/* hw/rtl/tcc_pkg.sv */
// ----------------------------------------------------------------------------
// tcc_pkg: text console package
// Shared constants, codes and payload types of the text console block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

	// store geometry defaults
	localparam int MAX_COLS_DEF = 128;
	localparam int MAX_ROWS_DEF = 32;

	// payload types
	typedef logic [1:0]  req_code_t;
	typedef logic [7:0]  char_t;
	typedef logic [4:0]  row_sel_t;
	typedef logic [6:0]  col_sel_t;
	typedef logic [15:0] cell_t;
	typedef logic [7:0]  cur_col_t;
	typedef logic [4:0]  cur_row_t;
	typedef logic [1:0]  cfg_idx_t;
	typedef logic [7:0]  cfg_data_t;

	// request codes
	localparam req_code_t REQ_PUT   = 2'd0;
	localparam req_code_t REQ_CLEAR = 2'd1;
	localparam req_code_t REQ_READ  = 2'd2;
	localparam req_code_t REQ_NONE  = 2'd3;

	// register indexes
	localparam cfg_idx_t REG_ENABLE = 2'd0;
	localparam cfg_idx_t REG_COLS   = 2'd1;
	localparam cfg_idx_t REG_ROWS   = 2'd2;
	localparam cfg_idx_t REG_ATTR   = 2'd3;

	// register reset values
	localparam logic [7:0] COLS_RST = 8'd80;
	localparam logic [5:0] ROWS_RST = 6'd25;
	localparam logic [7:0] ATTR_RST = 8'h07;

	// special characters
	localparam char_t CH_CR    = 8'd13;
	localparam char_t CH_LF    = 8'd10;
	localparam char_t CH_SPACE = 8'h20;

endpackage

`default_nettype wire

/* hw/rtl/tcc_if.sv */
// ----------------------------------------------------------------------------
// tcc_if: text console channel interfaces
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_req_if;
	import tcc_pkg::*;
	logic      valid;
	logic      ready;
	req_code_t req_type;
	char_t     char_code;
	row_sel_t  read_row;
	col_sel_t  read_col;
	modport source (output valid, req_type, char_code, read_row, read_col, input ready);
	modport sink   (input valid, req_type, char_code, read_row, read_col, output ready);
endinterface

interface tcc_rsp_if;
	import tcc_pkg::*;
	logic     valid;
	logic     ready;
	cell_t    cell_value;
	cur_col_t cursor_col;
	cur_row_t cursor_row;
	modport source (output valid, cell_value, cursor_col, cursor_row, input ready);
	modport sink   (input valid, cell_value, cursor_col, cursor_row, output ready);
endinterface

interface tcc_cfg_if;
	import tcc_pkg::*;
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tcc_cell_ram.sv */
// ----------------------------------------------------------------------------
// tcc_cell_ram: cell store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_cell_ram #(
	parameter int DEPTH = tcc_pkg::MAX_COLS_DEF * tcc_pkg::MAX_ROWS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire tcc_pkg::cell_t wdata,
	input  wire logic [AW-1:0] raddr,
	output tcc_pkg::cell_t     rdata
);
	import tcc_pkg::*;

	cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* hw/rtl/text_console_cursor_scroll_unit.sv */
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit: character-cell text console
// Cell store with cursor, wrap, scroll, clear and cell read-back.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat carries                               | ready
//  --------+-----+--------------------------------------------+------------------
//  cfg     | in  | index, data (enable/cols/rows/attribute)    | always high
//  req     | in  | req_type, char_code, read_row, read_col     | high in idle
//  rsp     | out | cell_value, cursor_col, cursor_row          | from consumer
//
//  Steps per request beat after accept: idle, decode, then by kind:
//    CR, LF without scroll, ignored codes, read outside the area: done;
//    read inside the area: read data, done; plain put: write, done.
//    Scroll and clear sweep the active area, one cell store write per cycle,
//    then done (a wrap that scrolls adds the character write before done).
//  The sweep is bounded by the single write port of the cell store.
//  Reset clears cursor, registers and control; the cell store is not cleared.
//  A full response register does not stop the next request being accepted;
//  that request then holds at its last step until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_scroll_unit #(
	parameter int MAX_COLS = tcc_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = tcc_pkg::MAX_ROWS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	tcc_cfg_if.sink   cfg,
	tcc_req_if.sink   req,
	tcc_rsp_if.source rsp
);
	import tcc_pkg::*;

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int KW    = $clog2(DEPTH + 1);   // sweep counter, reaches the area
	localparam int CW    = $clog2(MAX_COLS + 1); // column count / cursor column
	localparam int RW    = $clog2(MAX_ROWS + 1); // row count / cursor row
	localparam int PW    = CW + RW;              // product width

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_RDATA  = 3'd2;
	localparam logic [2:0] S_SWEEP  = 3'd3;
	localparam logic [2:0] S_WRITE  = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0] state_q;

	// registers
	logic       enable_q;
	logic [7:0] cols_q;
	logic [5:0] rows_q;
	logic [7:0] attr_q;

	// cursor
	logic [CW-1:0] x_q;
	logic [RW-1:0] y_q;

	// latched request
	req_code_t req_q;
	char_t     ch_q;
	row_sel_t  rr_q;
	col_sel_t  rc_q;

	// sweep engine
	logic [KW-1:0] k_q;
	logic [KW-1:0] area_q;
	logic          copy_q;   // scroll (copy up) vs clear
	logic          pend_q;   // character write follows the scroll
	logic          v_s1;
	logic [AW-1:0] addr_s1;
	logic          blank_s1;

	// response
	cell_t    res_value_q;
	logic     out_valid_q;
	cell_t    out_value_q;
	cur_col_t out_col_q;
	cur_row_t out_row_q;

	// cell store ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	cell_t         ram_wdata;
	logic [AW-1:0] ram_raddr;
	cell_t         ram_rdata;

	// derived
	logic [CW-1:0] eff_cols;
	logic [RW-1:0] eff_rows;
	logic [RW-1:0] rm1;
	logic [RW-1:0] ny_lf;
	logic [RW-1:0] ys;
	logic [RW-1:0] ny_pc;
	logic          in_rng;
	logic [PW-1:0] rd_prod;
	logic [PW-1:0] cur_prod;
	logic [KW-1:0] cp_end;
	logic          sweep_issue;
	logic          load_out;
	cell_t         blank;

	// effective geometry: counts saturate to 1..MAX
	always_comb begin
		if (cols_q == 8'd0) begin
			eff_cols = CW'(1);
		end else if ({1'b0, cols_q} > 9'(MAX_COLS)) begin
			eff_cols = CW'(MAX_COLS);
		end else begin
			eff_cols = CW'(cols_q);
		end
		if (rows_q == 6'd0) begin
			eff_rows = RW'(1);
		end else if ({1'b0, rows_q} > 7'(MAX_ROWS)) begin
			eff_rows = RW'(MAX_ROWS);
		end else begin
			eff_rows = RW'(rows_q);
		end
	end

	assign rm1   = eff_rows - RW'(1);
	assign ny_lf = y_q + RW'(1);
	assign ys    = (y_q >= eff_rows) ? rm1 : y_q;  // row left beyond a shrunk screen
	assign ny_pc = ys + RW'(1);
	assign blank = {attr_q, CH_SPACE};

	assign in_rng   = (9'(rr_q) < 9'(eff_rows)) && (9'(rc_q) < 9'(eff_cols));
	assign rd_prod  = PW'(rr_q) * PW'(eff_cols) + PW'(rc_q);
	assign cur_prod = PW'(y_q) * PW'(eff_cols) + PW'(x_q);

	// rows 1..rows-1 move up; beyond that the sweep writes blanks
	assign cp_end      = area_q - KW'(eff_cols);
	assign sweep_issue = (state_q == S_SWEEP) && (k_q != area_q);
	assign load_out    = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// cell store access: sweep writes land in the cycle after their read
	always_comb begin
		if (state_q == S_DECODE) begin
			ram_raddr = rd_prod[AW-1:0];
		end else begin
			ram_raddr = AW'(k_q + KW'(eff_cols));
		end
		ram_we = v_s1 || (state_q == S_WRITE);
		if (v_s1) begin
			ram_waddr = addr_s1;
			ram_wdata = blank_s1 ? blank : ram_rdata;
		end else begin
			ram_waddr = cur_prod[AW-1:0];
			ram_wdata = {attr_q, ch_q};
		end
	end

	tcc_cell_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			enable_q    <= 1'b0;
			cols_q      <= COLS_RST;
			rows_q      <= ROWS_RST;
			attr_q      <= ATTR_RST;
			x_q         <= '0;
			y_q         <= '0;
			k_q         <= '0;
			copy_q      <= 1'b0;
			pend_q      <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_ENABLE: enable_q <= cfg.data[0];
					REG_COLS:   cols_q   <= cfg.data;
					REG_ROWS:   rows_q   <= cfg.data[5:0];
					REG_ATTR:   attr_q   <= cfg.data;
					default:    ;
				endcase
			end

			v_s1 <= sweep_issue;
			if (sweep_issue) begin
				k_q <= k_q + KW'(1);
			end

			// a load in the same cycle as a taken beat keeps the register full
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					priority if (req_q == REQ_READ) begin
						state_q <= in_rng ? S_RDATA : S_DONE;
					end else if (!enable_q || req_q == REQ_NONE) begin
						state_q <= S_DONE;
					end else if (req_q == REQ_CLEAR) begin
						x_q     <= '0;
						y_q     <= '0;
						k_q     <= '0;
						copy_q  <= 1'b0;
						pend_q  <= 1'b0;
						state_q <= S_SWEEP;
					end else if (ch_q == CH_CR) begin
						x_q     <= '0;
						state_q <= S_DONE;
					end else if (ch_q == CH_LF) begin
						x_q <= '0;
						if (ny_lf >= eff_rows) begin
							y_q     <= rm1;
							k_q     <= '0;
							copy_q  <= 1'b1;
							pend_q  <= 1'b0;
							state_q <= S_SWEEP;
						end else begin
							y_q     <= ny_lf;
							state_q <= S_DONE;
						end
					end else if (x_q >= eff_cols) begin
						// wrap before writing
						x_q <= '0;
						if (ny_pc >= eff_rows) begin
							y_q     <= rm1;
							k_q     <= '0;
							copy_q  <= 1'b1;
							pend_q  <= 1'b1;
							state_q <= S_SWEEP;
						end else begin
							y_q     <= ny_pc;
							state_q <= S_WRITE;
						end
					end else begin
						y_q     <= ys;
						state_q <= S_WRITE;
					end
				end
				S_RDATA: begin
					state_q <= S_DONE;
				end
				S_SWEEP: begin
					if (!sweep_issue && !v_s1) begin
						state_q <= pend_q ? S_WRITE : S_DONE;
					end
				end
				S_WRITE: begin
					x_q     <= x_q + CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= req.req_type;
			ch_q  <= req.char_code;
			rr_q  <= req.read_row;
			rc_q  <= req.read_col;
		end
		area_q <= KW'(PW'(eff_rows) * PW'(eff_cols));
		if (sweep_issue) begin
			addr_s1  <= k_q[AW-1:0];
			blank_s1 <= !(copy_q && (k_q < cp_end));
		end
		if (state_q == S_DECODE) begin
			res_value_q <= '0;
		end else if (state_q == S_RDATA) begin
			res_value_q <= ram_rdata;
		end
		if (load_out) begin
			out_value_q <= res_value_q;
			out_col_q   <= cur_col_t'(x_q);
			out_row_q   <= cur_row_t'(y_q);
		end
	end

	assign cfg.ready      = 1'b1;
	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.cell_value = out_value_q;
	assign rsp.cursor_col = out_col_q;
	assign rsp.cursor_row = out_row_q;

	// checks
	a_write_in_area: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> (y_q < eff_rows && x_q < eff_cols))
		else $error("character write outside active area");

	a_sweep_in_area: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (KW'(addr_s1) < area_q))
		else $error("sweep write beyond active area");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("cell store written while idle");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished request did not reach response register");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the text console block
// Drives put, clear, read and unused requests through the request channel,
// programs the registers between phases, and checks every response beat
// against an in-bench model of the cell store and cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tcc_pkg::*;

	// one request beat as queued for the driver
	typedef struct packed {
		req_code_t kind;
		char_t     ch;
		row_sel_t  row;
		col_sel_t  col;
	} console_req_t;

	// one response beat as the console model predicts it
	typedef struct packed {
		cell_t    cell_val;
		cur_col_t col;
		cur_row_t row;
	} console_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tcc_cfg_if cfg_ch ();
	tcc_req_if req_ch ();
	tcc_rsp_if rsp_ch ();

	text_console_cursor_scroll_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Console model: shadow registers, cell store and cursor.
	// Cursor kept as int: the row can pass the last row for a moment before
	// a scroll, and both can sit beyond a shrunken screen.
	// ------------------------------------------------------------------------
	cell_t     screen [0:MAX_COLS_DEF*MAX_ROWS_DEF-1];
	int        cur_x;
	int        cur_y;
	bit        reg_en;
	cfg_data_t reg_cols;
	logic [5:0] reg_rows;
	cfg_data_t reg_attr;

	console_req_t pending_q[$];   // requests not yet driven
	console_rsp_t expected_q[$];  // responses owed by the block, oldest first

	int  queued_cnt;     // request beats handed to the driver
	int  accepted_cnt;   // request beats the block took
	int  checked_cnt;
	int  mismatch_cnt;
	int  scroll_cnt;
	int  put_cnt, clear_cnt, read_cnt, unused_cnt;
	bit  no_gaps;        // both sides run without idle cycles

	// zero means one, anything above the store size saturates
	function automatic int clamp_count(input int v, input int hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic void apply_register(input cfg_idx_t idx, input cfg_data_t value);
		case (idx)
			REG_ENABLE: reg_en   = value[0];
			REG_COLS:   reg_cols = value;
			REG_ROWS:   reg_rows = value[5:0];
			REG_ATTR:   reg_attr = value;
			default: ;
		endcase
	endfunction

	// shift rows up by one, blank the bottom row, park cursor on it
	function automatic void scroll_up(input int cols, input int rows);
		for (int y = 1; y < rows; y++)
			for (int x = 0; x < cols; x++)
				screen[(y - 1) * cols + x] = screen[y * cols + x];
		for (int x = 0; x < cols; x++)
			screen[(rows - 1) * cols + x] = {reg_attr, CH_SPACE};
		cur_y = rows - 1;
		scroll_cnt++;
	endfunction

	function automatic void type_char(input char_t ch, input int cols, input int rows);
		if (ch == CH_CR) begin
			cur_x = 0;
		end else if (ch == CH_LF) begin
			cur_x = 0;
			cur_y++;
			if (cur_y >= rows)
				scroll_up(cols, rows);
		end else begin
			// row left beyond a shrunken screen: pin it, no scroll
			if (cur_y >= rows)
				cur_y = rows - 1;
			// wrap at the column limit, scrolling if that leaves the screen
			if (cur_x >= cols) begin
				cur_x = 0;
				cur_y++;
				if (cur_y >= rows)
					scroll_up(cols, rows);
			end
			screen[cur_y * cols + cur_x] = {reg_attr, ch};
			cur_x++;
		end
	endfunction

	function automatic void blank_screen(input int cols, input int rows);
		for (int i = 0; i < rows * cols; i++)
			screen[i] = {reg_attr, CH_SPACE};
		cur_x = 0;
		cur_y = 0;
	endfunction

	// apply one accepted request, return the response it owes
	function automatic console_rsp_t advance_console(input console_req_t r);
		console_rsp_t res;
		int cols;
		int rows;
		cols = clamp_count(int'(reg_cols), MAX_COLS_DEF);
		rows = clamp_count(int'(reg_rows), MAX_ROWS_DEF);
		res.cell_val = '0;
		case (r.kind)
			REQ_PUT: begin
				put_cnt++;
				if (reg_en)
					type_char(r.ch, cols, rows);
			end
			REQ_CLEAR: begin
				clear_cnt++;
				if (reg_en)
					blank_screen(cols, rows);
			end
			REQ_READ: begin
				read_cnt++;
				// outside the active area reads as zero
				if (r.row < rows && r.col < cols)
					res.cell_val = screen[r.row * cols + r.col];
			end
			default: unused_cnt++;
		endcase
		res.col = cur_col_t'(cur_x);
		res.row = cur_row_t'(cur_y);
		return res;
	endfunction

	task automatic report(input string msg);
		if (mismatch_cnt < 50)
			$display("ERROR @%0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	// ------------------------------------------------------------------------
	// Request driver. Register writes are folded into the shadow here too,
	// so the shadow is always current when a request beat is predicted.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : req_driver
		console_req_t nxt;
		console_req_t cur;
		if (!arst_n) begin
			req_ch.valid     <= 1'b0;
			req_ch.req_type  <= REQ_PUT;
			req_ch.char_code <= '0;
			req_ch.read_row  <= '0;
			req_ch.read_col  <= '0;
			reg_en   = 1'b0;
			reg_cols = COLS_RST;
			reg_rows = ROWS_RST;
			reg_attr = ATTR_RST;
			cur_x    = 0;
			cur_y    = 0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready)
				apply_register(cfg_ch.index, cfg_ch.data);
			if (req_ch.valid && req_ch.ready) begin
				cur.kind = req_ch.req_type;
				cur.ch   = req_ch.char_code;
				cur.row  = req_ch.read_row;
				cur.col  = req_ch.read_col;
				expected_q.push_back(advance_console(cur));
				accepted_cnt++;
			end
			// load a new beat once the old one is gone (or none was up)
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_q.size() != 0 && (no_gaps || $urandom_range(99) >= 11)) begin
					nxt = pending_q.pop_front();
					req_ch.valid     <= 1'b1;
					req_ch.req_type  <= nxt.kind;
					req_ch.char_code <= nxt.ch;
					req_ch.read_row  <= nxt.row;
					req_ch.read_col  <= nxt.col;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Response monitor: random backpressure, field-by-field compare
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		console_rsp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				checked_cnt++;
				if (expected_q.size() == 0) begin
					report("response beat with no request outstanding");
				end else begin
					want = expected_q.pop_front();
					if (rsp_ch.cell_value !== want.cell_val)
						report($sformatf("beat %0d cell_value %h, want %h",
							checked_cnt, rsp_ch.cell_value, want.cell_val));
					if (rsp_ch.cursor_col !== want.col)
						report($sformatf("beat %0d cursor_col %0d, want %0d",
							checked_cnt, rsp_ch.cursor_col, want.col));
					if (rsp_ch.cursor_row !== want.row)
						report($sformatf("beat %0d cursor_row %0d, want %0d",
							checked_cnt, rsp_ch.cursor_row, want.row));
				end
			end
			rsp_ch.ready <= no_gaps || ($urandom_range(99) >= 11);
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic write_register(input cfg_idx_t idx, input cfg_data_t value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do begin
			@(posedge clk);
		end while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic void queue_req(input req_code_t kind, input char_t ch,
			input row_sel_t row, input col_sel_t col);
		console_req_t r;
		r.kind = kind;
		r.ch   = ch;
		r.row  = row;
		r.col  = col;
		pending_q.push_back(r);
		queued_cnt++;
	endfunction

	// sender holds off until every queued beat went in and came back
	task automatic drain();
		while (accepted_cnt != queued_cnt || expected_q.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main_seq
		int        random_items;
		int        phase;
		int        count;
		int        plan_cols;
		int        plan_rows;
		int        pick;
		int        c;
		bit        big;
		cfg_data_t cols_d;
		cfg_data_t rows_d;
		cfg_data_t en_d;
		char_t     ch;
		row_sel_t  row;
		col_sel_t  col;

		// register channel known from time zero
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_ENABLE;
		cfg_ch.data  = '0;
		no_gaps = 1'b0;
		random_items = 0;
		phase = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed: default 80x25 screen, enabled
		// the store powers up unknown, so a clear comes before any read
		write_register(REG_ENABLE, 8'h01);
		queue_req(REQ_CLEAR, 8'h00, 5'd0, 7'd0);
		queue_req(REQ_READ,  8'h00, 5'd0, 7'd0);
		queue_req(REQ_PUT,   8'h41, 5'd0, 7'd0);
		queue_req(REQ_PUT,   8'hFF, 5'd31, 7'd127);
		queue_req(REQ_PUT,   8'h00, 5'd0, 7'd0);
		queue_req(REQ_PUT,   CH_CR, 5'd0, 7'd0);
		queue_req(REQ_PUT,   8'h42, 5'd0, 7'd0);
		queue_req(REQ_PUT,   CH_LF, 5'd0, 7'd0);
		queue_req(REQ_READ,  8'h00, 5'd0, 7'd0);
		queue_req(REQ_READ,  8'hFF, 5'd0, 7'd1);
		queue_req(REQ_READ,  8'h00, 5'd31, 7'd127);  // far outside
		queue_req(REQ_READ,  8'h00, 5'd0, 7'd80);    // just past last column
		queue_req(REQ_READ,  8'h00, 5'd25, 7'd0);    // just past last row
		queue_req(REQ_NONE,  8'hFF, 5'd31, 7'd127);
		drain();

		// --- directed: zero counts mean a 1x1 screen; cursor row left at 1
		// gets pinned, then wrap and line feed both scroll
		write_register(REG_COLS, 8'h00);
		write_register(REG_ROWS, 8'h00);
		write_register(REG_ATTR, 8'h00);
		queue_req(REQ_PUT,  8'h55, 5'd0, 7'd0);
		queue_req(REQ_PUT,  8'h66, 5'd0, 7'd0);
		queue_req(REQ_PUT,  CH_LF, 5'd0, 7'd0);
		queue_req(REQ_READ, 8'h00, 5'd0, 7'd0);
		queue_req(REQ_READ, 8'h00, 5'd0, 7'd1);
		drain();

		// --- directed: disabled console ignores put and clear
		write_register(REG_ENABLE, 8'hFE);
		queue_req(REQ_PUT,   8'h77, 5'd0, 7'd0);
		queue_req(REQ_CLEAR, 8'h00, 5'd0, 7'd0);
		queue_req(REQ_READ,  8'h00, 5'd0, 7'd0);
		drain();

		// --- directed: oversized counts saturate to the full store.
		// This clear writes every cell, so later geometries never read
		// an unwritten one.
		write_register(REG_ENABLE, 8'h01);
		write_register(REG_COLS, 8'hFF);
		write_register(REG_ROWS, 8'hFF);
		write_register(REG_ATTR, 8'hFF);
		queue_req(REQ_CLEAR, 8'h00, 5'd0, 7'd0);
		queue_req(REQ_PUT,   8'h80, 5'd0, 7'd0);
		queue_req(REQ_READ,  8'h00, 5'd31, 7'd127);
		drain();

		// --- random phases; mostly small screens so sweeps stay short,
		// now and then a large one with few requests
		while (random_items < 1000) begin
			big = ($urandom_range(11) == 0);
			if (big) begin
				case ($urandom_range(3))
					0: cols_d = 8'hFF;
					1: cols_d = 8'd128;
					2: cols_d = 8'd127;
					default: cols_d = cfg_data_t'($urandom_range(255, 64));
				endcase
				case ($urandom_range(3))
					0: rows_d = 8'h3F;
					1: rows_d = 8'd32;
					2: rows_d = 8'd31;
					default: rows_d = cfg_data_t'($urandom_range(63, 16));
				endcase
				count = $urandom_range(25, 10);
			end else begin
				cols_d = cfg_data_t'($urandom_range(12, 0));
				rows_d = cfg_data_t'($urandom_range(6, 0));
				count = $urandom_range(90, 40);
			end
			en_d = cfg_data_t'($urandom_range(255, 0));
			en_d[0] = ($urandom_range(9) != 0);
			plan_cols = clamp_count(int'(cols_d), MAX_COLS_DEF);
			plan_rows = clamp_count(int'(rows_d[5:0]), MAX_ROWS_DEF);

			// one phase runs flat out on both sides
			no_gaps = (phase == 3);

			write_register(REG_COLS, cols_d);
			write_register(REG_ROWS, rows_d);
			write_register(REG_ATTR, cfg_data_t'($urandom_range(255, 0)));
			write_register(REG_ENABLE, en_d);

			for (int k = 0; k < count; k++) begin
				pick = $urandom_range(99);
				row = row_sel_t'($urandom_range(31, 0));
				col = col_sel_t'($urandom_range(127, 0));
				ch = char_t'($urandom_range(255, 0));
				if (pick < 62) begin
					// text stream with line breaks mixed in
					c = $urandom_range(99);
					if (c < 15)
						ch = CH_LF;
					else if (c < 23)
						ch = CH_CR;
					queue_req(REQ_PUT, ch, row, col);
				end else if (pick < (big ? 63 : 66)) begin
					queue_req(REQ_CLEAR, ch, row, col);
				end else if (pick < 94) begin
					// mostly inside the screen, rest anywhere
					if ($urandom_range(3) != 0) begin
						row = row_sel_t'($urandom_range(plan_rows - 1, 0));
						col = col_sel_t'($urandom_range(plan_cols - 1, 0));
					end
					queue_req(REQ_READ, ch, row, col);
				end else begin
					queue_req(REQ_NONE, ch, row, col);
				end
				random_items++;
			end
			drain();
			phase++;
		end
		no_gaps = 1'b0;

		// trailing pause catches stray response beats
		repeat (8) @(posedge clk);

		$display("Covered %0d requests: %0d puts, %0d clears, %0d reads, %0d unused codes",
			accepted_cnt, put_cnt, clear_cnt, read_cnt, unused_cnt);
		$display("%0d random register phases, %0d scrolls, %0d responses compared",
			phase, scroll_cnt, checked_cnt);
		if (mismatch_cnt == 0 && expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run (every beat a full sweep)
	initial begin : watchdog
		#400_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
